/* sv/sorted_tuple_table_probe_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted tuple table probe
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TUPLE_TABLE_PROBE_DEFINES_SVH
`define SORTED_TUPLE_TABLE_PROBE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/stt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted tuple table probe package
// Sizes, beat types, codes and small helpers shared by the table modules.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int ENTRIES    = 1024;
    localparam int KEY_WORDS  = 4;
    localparam int IN_KEYS    = 4;
    localparam int ACT_WORDS  = (KEY_WORDS < IN_KEYS) ? KEY_WORDS : IN_KEYS;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int POS_W      = 11;
    localparam int KLEN_W     = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(4);

    typedef logic [APB_ADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_KEY_LEN = t_reg_idx'(0);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_PROBE  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_SORT0,
        S_SORT1,
        S_SORT2,
        S_SREAD,
        S_SCMP,
        S_FCMP,
        S_EMIT
    } t_state;

    typedef logic [WORD_W-1:0]                  t_word;
    typedef logic [IN_KEYS-1:0][WORD_W-1:0]     t_pkey;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]   t_row;

    typedef struct packed {
        t_kind                     kind;
        logic signed [WORD_W-1:0]  key_0;
        logic signed [WORD_W-1:0]  key_1;
        logic signed [WORD_W-1:0]  key_2;
        logic signed [WORD_W-1:0]  key_3;
        logic signed [WORD_W-1:0]  entry_value;
    } t_in_item;

    typedef struct packed {
        logic                      status;
        logic                      found;
        logic signed [WORD_W-1:0]  found_value;
        logic [POS_W-1:0]          position;
    } t_out_item;

    // Result of comparing a stored row against the probe key.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    function automatic logic word_less(input t_word a, input t_word b);
        return $signed(a) < $signed(b);
    endfunction

    // Number of key words in use: zero counts as one, and the count never
    // exceeds the stored or supplied words.
    function automatic logic [KLEN_W-1:0] active_len(input logic [KLEN_W-1:0] k);
        logic [KLEN_W-1:0] n;
        n = k;
        if (n == '0) n = KLEN_W'(1);
        if (int'(n) > ACT_WORDS) n = KLEN_W'(ACT_WORDS);
        return n;
    endfunction

endpackage

/* sv/stt_key_cmp.sv */
// ----------------------------------------------------------------------------
// Composite key comparator
// Lexicographic signed compare of a stored row against the probe key.
// ----------------------------------------------------------------------------
module stt_key_cmp
    import stt_pkg::*;
(
    input  t_row                  i_row,
    input  t_row                  i_probe,
    input  logic [KEY_WORDS-1:0]  i_act,
    output t_cmp                  o_cmp
);

    // Walk from the last word down so that the first differing word wins.
    always_comb begin
        o_cmp.lt = 1'b0;
        o_cmp.eq = 1'b1;
        for (int j = KEY_WORDS - 1; j >= 0; j--) begin
            if (i_act[j] && (i_row[j] != i_probe[j])) begin
                o_cmp.lt = word_less(i_row[j], i_probe[j]);
                o_cmp.eq = 1'b0;
            end
        end
    end

endmodule

/* sv/sorted_tuple_table_probe.sv */
// ----------------------------------------------------------------------------
// Sorted tuple table probe
// A table of up to 1024 entries, each a key of four signed 32-bit words and
// a signed 32-bit value, loaded one entry per append beat in ascending key
// order. A probe beat sorts its first key_len words ascending and returns
// the lower-bound position of that key, whether the entry there matches,
// and its value. A clear beat empties the table, and an append into a full
// table is dropped with status 1. Every input beat yields exactly one
// result beat. One item is in flight at a time, so a new beat is taken only
// once the last result has been loaded. A probe runs the sort states, then
// k halving steps of the search, where k is at most
// ceil(log2(entry_count + 1)), plus a closing check when the search ends on
// an entry inside the table. Each step is one read of the key memory, whose
// data comes back registered, and one compare, and the closing check of the
// lower-bound entry costs one more read. While the result register is still
// full, the block waits in its emit state before loading the next result.
// The key_len register sits at byte address 0 of the APB port; the user is
// to write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module sorted_tuple_table_probe
    import stt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [KLEN_W-1:0]  r_key_len;
    logic               r_out_valid;

    // Working registers of the item in flight.
    t_in_item           r_item, n_item;
    t_pkey              r_key, n_key;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_mid, n_mid;
    t_out_item          r_res, n_res;
    t_out_item          r_out;

    // Table memories: one key row and one value per entry.
    t_row               r_key_mem [ENTRIES];
    t_word              r_val_mem [ENTRIES];
    t_row               r_row_rd;
    t_word              r_val_rd;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    t_row               mem_wrow;
    t_word              mem_wval;

    logic               in_acc;
    logic               out_free;
    logic               load_out;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic [KLEN_W-1:0]  klen;
    logic [IN_KEYS-1:0] act_in;
    logic [KEY_WORDS-1:0] act_row;
    t_pkey              item_keys;
    t_row               probe_row;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    t_cmp               cmp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign load_out    = (r_state == S_EMIT) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so no access waits.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_KEY_LEN) begin
            prdata = APB_DATA_W'(r_key_len);
        end
    end

    // ------------------------------------------------------------------
    // Key word masks. The active words always form a prefix of the key,
    // which is what lets the sort network skip inactive lanes.
    // ------------------------------------------------------------------
    assign klen = active_len(r_key_len);

    always_comb begin
        for (int j = 0; j < IN_KEYS; j++) begin
            act_in[j] = (j < int'(klen));
        end
        for (int j = 0; j < KEY_WORDS; j++) begin
            act_row[j] = (j < int'(klen));
        end
    end

    // The appended row holds the supplied words as given, zero beyond them;
    // the probe row is the sorted probe key laid out the same way.
    assign item_keys = {r_item.key_3, r_item.key_2, r_item.key_1, r_item.key_0};

    always_comb begin
        for (int j = 0; j < KEY_WORDS; j++) begin
            mem_wrow[j]  = '0;
            probe_row[j] = '0;
            if (j < IN_KEYS) begin
                mem_wrow[j]  = item_keys[j];
                probe_row[j] = r_key[j];
            end
        end
    end

    assign mem_wval  = r_item.entry_value;
    assign mem_waddr = r_count[IDX_W-1:0];

    // Midpoint of the remaining search window.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];

    stt_key_cmp u_key_cmp (
        .i_row   (r_row_rd),
        .i_probe (probe_row),
        .i_act   (act_row),
        .o_cmp   (cmp)
    );

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.kind == KIND_PROBE) ? S_SORT0 : S_APPLY;
                end
            end
            S_APPLY: n_state = S_EMIT;
            S_SORT0: n_state = S_SORT1;
            S_SORT1: n_state = S_SORT2;
            S_SORT2: n_state = S_SREAD;
            S_SREAD: begin
                if (r_lo < r_hi) begin
                    n_state = S_SCMP;
                end else if (r_lo < r_count) begin
                    n_state = S_FCMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCMP: n_state = S_SREAD;
            S_FCMP: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory controls for each state.
    // ------------------------------------------------------------------
    always_comb begin
        n_count   = r_count;
        n_item    = r_item;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_raddr = r_lo[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_data;
                    n_key  = {i_in_data.key_3, i_in_data.key_2,
                              i_in_data.key_1, i_in_data.key_0};
                    n_lo   = '0;
                    n_hi   = r_count;
                end
            end

            S_APPLY: begin
                n_res = '0;
                unique case (r_item.kind) inside
                    KIND_APPEND: begin
                        n_res.position = POS_W'(r_count);
                        if (r_count >= CNT_W'(ENTRIES)) begin
                            n_res.status = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    KIND_CLEAR: begin
                        n_count = '0;
                    end
                    KIND_PROBE, KIND_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end

            // Five-comparator sort network over S_SORT0, S_SORT1 and S_SORT2. A pair swaps
            // only when its upper lane is active, so inactive words stay put.
            S_SORT0: begin
                if (act_in[1] && word_less(r_key[1], r_key[0])) begin
                    n_key[0] = r_key[1];
                    n_key[1] = r_key[0];
                end
                if (act_in[3] && word_less(r_key[3], r_key[2])) begin
                    n_key[2] = r_key[3];
                    n_key[3] = r_key[2];
                end
            end
            S_SORT1: begin
                if (act_in[2] && word_less(r_key[2], r_key[0])) begin
                    n_key[0] = r_key[2];
                    n_key[2] = r_key[0];
                end
                if (act_in[3] && word_less(r_key[3], r_key[1])) begin
                    n_key[1] = r_key[3];
                    n_key[3] = r_key[1];
                end
            end
            S_SORT2: begin
                if (act_in[2] && word_less(r_key[2], r_key[1])) begin
                    n_key[1] = r_key[2];
                    n_key[2] = r_key[1];
                end
            end

            S_SREAD: begin
                if (r_lo < r_hi) begin
                    mem_raddr = mid[IDX_W-1:0];
                    n_mid     = mid;
                end else if (r_lo < r_count) begin
                    mem_raddr = r_lo[IDX_W-1:0];
                end else begin
                    n_res          = '0;
                    n_res.position = POS_W'(r_lo);
                end
            end

            S_SCMP: begin
                if (cmp.lt) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
            end

            S_FCMP: begin
                n_res          = '0;
                n_res.position = POS_W'(r_lo);
                if (cmp.eq) begin
                    n_res.found       = 1'b1;
                    n_res.found_value = r_val_rd;
                end
            end

            S_EMIT: begin
            end

            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_key_len   <= KLEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (cfg_wr && (reg_idx == REG_KEY_LEN)) begin
                r_key_len <= pwdata[KLEN_W-1:0];
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_key  <= n_key;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_res  <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    // Table memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[mem_waddr] <= mem_wrow;
            r_val_mem[mem_waddr] <= mem_wval;
        end
        r_row_rd <= r_key_mem[mem_raddr];
        r_val_rd <= r_val_mem[mem_raddr];
    end

endmodule

/* sv/stt_checker.sv */
// ----------------------------------------------------------------------------
// Sorted tuple table probe port checker
// Watches the top-level ports and flags inconsistent result beats and input taken while busy.
// ----------------------------------------------------------------------------
`include "sorted_tuple_table_probe_defines.svh"

module stt_checker
    import stt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_ready,
    input  logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  t_out_item              o_out_data
);

    // A stalled result beat must hold.
    `STT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // One item at a time: the block is busy right after it takes a beat.
    `STT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken again while an item is in flight")

    // A miss never carries a value.
    `STT_ASSERT_IMP(a_miss_zero_value, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.found_value == 0, "value reported without a match")

    // A hit points inside the table and is never a dropped append.
    `STT_ASSERT_IMP(a_hit_in_range, i_clk, i_rst_n, o_out_valid && o_out_data.found, !o_out_data.status && (o_out_data.position < ENTRIES), "match reported outside the table")

endmodule

bind sorted_tuple_table_probe stt_checker u_stt_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted tuple table probe
// Drives append, probe, clear and no-op beats through the valid/ready input
// channel and checks each result beat against an in-bench table model or a
// given want. A short table of directed beats runs first. Random phases
// follow, each setting key_len from a plan, with sorted tables, one long
// table, unsorted appends and noise. Both ends stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;
    import stt_pkg::*;

    localparam int NO_CFG         = -1;
    localparam int PHASES         = 9;
    localparam int FILL_PHASE     = 4;
    localparam int OPS_PER_PHASE  = 40;
    // Enough for the block to settle once the last result has arrived.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    localparam t_word W_ZERO = 32'h0000_0000;
    localparam t_word W_ONES = 32'hFFFF_FFFF;
    localparam t_word W_MIN  = 32'h8000_0000;
    localparam t_word W_MAX  = 32'h7FFF_FFFF;

    localparam logic [APB_ADDR_W-1:0] KEY_LEN_ADDR = {REG_KEY_LEN, 2'b00};

    // One row of the directed table. When cfg_en is set, key_len is written
    // before the beat goes out. When typed is set, want is the expected result.
    // Otherwise the table model decides.
    typedef struct packed {
        logic              cfg_en;
        logic [KLEN_W-1:0] cfg_val;
        logic              typed;
        t_in_item          beat;
        t_out_item         want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Table model state. It mirrors what the block should hold.
    t_pkey             mirror_keys [ENTRIES];
    t_word             mirror_vals [ENTRIES];
    int                mirror_count = 0;
    logic [KLEN_W-1:0] mirror_klen  = KLEN_RESET;

    t_out_item pending_results [$];
    t_stim_row dir_rows [$];

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     mismatch_count = 0;
    int     quiet_cycles = 0;
    longint walk [IN_KEYS];
    int     klen_plan [PHASES] = '{1, 4, 2, 0, 4, 3, 7, 5, 1};

    sorted_tuple_table_probe dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The receiver decides afresh at every falling edge whether it takes a beat.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------

    // Words taken part in a compare: zero counts as one, and anything beyond
    // the supplied key words is clipped.
    function automatic int eff_len(input logic [KLEN_W-1:0] k);
        int n;
        n = int'(k);
        if (n < 1) n = 1;
        if (n > ACT_WORDS) n = ACT_WORDS;
        return n;
    endfunction

    // Lexicographic signed order of a stored row against the probe key over
    // its first n words: -1 when the row is smaller, 0 when equal, 1 when greater.
    function automatic int row_order(input int idx, input t_pkey probe, input int n);
        for (int j = 0; j < n; j++) begin
            if (mirror_keys[idx][j] != probe[j])
                return ($signed(mirror_keys[idx][j]) < $signed(probe[j])) ? -1 : 1;
        end
        return 0;
    endfunction

    // Applies one accepted beat to the model and returns the result it causes.
    function automatic t_out_item table_model_step(input t_in_item beat);
        t_out_item r;
        t_pkey     k;
        t_word     w;
        int        n;
        int        j;
        int        lo;
        int        hi;
        int        mid;
        r = '0;
        k = {beat.key_3, beat.key_2, beat.key_1, beat.key_0};
        case (beat.kind)
            KIND_APPEND: begin
                r.position = POS_W'(mirror_count);
                if (mirror_count >= ENTRIES) begin
                    r.status = 1'b1;
                end else begin
                    mirror_keys[mirror_count] = k;
                    mirror_vals[mirror_count] = beat.entry_value;
                    mirror_count++;
                end
            end
            KIND_PROBE: begin
                n = eff_len(mirror_klen);
                // The probe puts its active words in ascending signed order first.
                for (int i = 1; i < n; i++) begin
                    w = k[i];
                    j = i;
                    while (j > 0 && $signed(w) < $signed(k[j-1])) begin
                        k[j] = k[j-1];
                        j--;
                    end
                    k[j] = w;
                end
                lo = 0;
                hi = mirror_count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (row_order(mid, k, n) < 0) lo = mid + 1;
                    else hi = mid;
                end
                r.position = POS_W'(lo);
                if (lo < mirror_count && row_order(lo, k, n) == 0) begin
                    r.found       = 1'b1;
                    r.found_value = mirror_vals[lo];
                end
            end
            KIND_CLEAR: begin
                mirror_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_item mk_beat(input t_kind kd, input t_word k0, input t_word k1,
                                         input t_word k2, input t_word k3, input t_word v);
        t_in_item b;
        b.kind        = kd;
        b.key_0       = k0;
        b.key_1       = k1;
        b.key_2       = k2;
        b.key_3       = k3;
        b.entry_value = v;
        return b;
    endfunction

    function automatic t_out_item mk_res(input logic st, input logic fd, input t_word fv,
                                         input int pos);
        t_out_item r;
        r.status      = st;
        r.found       = fd;
        r.found_value = fv;
        r.position    = POS_W'(pos);
        return r;
    endfunction

    function automatic void add_row(input int cfg, input t_in_item beat, input logic typed,
                                    input t_out_item want);
        t_stim_row row;
        row.cfg_en  = (cfg != NO_CFG);
        row.cfg_val = KLEN_W'(cfg);
        row.typed   = typed;
        row.beat    = beat;
        row.want    = want;
        dir_rows = {dir_rows, row};
    endfunction

    // The key walk yields keys in ascending lexicographic order, and the words
    // of each key are in ascending order too. So the table stays sorted for
    // every key_len, and a shuffled copy of a row's prefix is a hit. Small
    // steps on the later words give many rows that share a prefix.
    function automatic void reset_key_walk();
        walk[0] = longint'($urandom_range(32'hC000_0000)) - 64'sd2147483648;
        for (int j = 1; j < IN_KEYS; j++) walk[j] = walk[j-1] + longint'($urandom_range(3));
    endfunction

    function automatic t_pkey next_walk_key();
        t_pkey k;
        int    p;
        p = $urandom_range(IN_KEYS - 1);
        walk[p] += (p == 0) ? longint'($urandom_range(1000, 1)) : longint'($urandom_range(20, 1));
        for (int j = p + 1; j < IN_KEYS; j++) walk[j] = walk[j-1] + longint'($urandom_range(3));
        for (int j = 0; j < IN_KEYS; j++) k[j] = t_word'(walk[j]);
        return k;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Presents one beat from a falling edge, after a random gap, and holds it
    // until it is accepted. Returns at the rising edge of the acceptance, so
    // valid stays high only if the next beat follows at once.
    task automatic push_beat(input t_in_item beat, input logic typed, input t_out_item want);
        t_out_item model_res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (!in_ready);
        model_res = table_model_step(beat);
        pending_results = {pending_results, (typed ? want : model_res)};
    endtask

    // Holds the sender off until every expected result has arrived and the
    // block has had time to fall idle.
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= KEY_LEN_ADDR;
        pwdata  <= wr ? data : '0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr)
            mirror_klen = data[KLEN_W-1:0];
        else if (prdata !== APB_DATA_W'(mirror_klen))
            note_mismatch("key_len readback", APB_DATA_W'(mirror_klen), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // key_len is only touched while the block is idle, and it is read back.
    task automatic set_key_len(input logic [KLEN_W-1:0] val);
        wait_results_drained();
        apb_cycle(1'b1, APB_DATA_W'(val));
        apb_cycle(1'b0, '0);
    endtask

    task automatic push_probe(input t_pkey k);
        push_beat(mk_beat(KIND_PROBE, k[0], k[1], k[2], k[3], $urandom), 1'b0, '0);
    endtask

    task automatic push_walk_append();
        t_pkey k;
        k = next_walk_key();
        push_beat(mk_beat(KIND_APPEND, k[0], k[1], k[2], k[3], $urandom), 1'b0, '0);
    endtask

    task automatic run_random_phase(input int ph);
        t_pkey k;
        t_word tmp;
        int    op;
        int    n;
        int    j;
        int    build_n;
        // Receiver-heavy stalls first, then sender-heavy, then none at all.
        if (ph < 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 72;
        end else if (ph < 6) begin
            send_idle_pct = 72;
            recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        set_key_len(KLEN_W'(klen_plan[ph]));
        push_beat(mk_beat(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom),
                  1'b0, '0);
        reset_key_walk();
        // One phase builds a long table, so the search runs many halving steps.
        if (ph == FILL_PHASE)
            build_n = 200;
        else if ($urandom_range(7) == 0)
            build_n = $urandom_range(150, 60);
        else
            build_n = $urandom_range(30);
        repeat (build_n) push_walk_append();

        repeat (OPS_PER_PHASE) begin
            op = $urandom_range(99);
            n  = eff_len(mirror_klen);
            if (op < 65 && mirror_count > 0) begin
                // Hit on a stored row, or a near miss one word off it. Words past
                // the active length are junk and must not matter.
                k = mirror_keys[$urandom_range(mirror_count - 1)];
                if (op >= 45) begin
                    j = $urandom_range(n - 1);
                    k[j] = $urandom_range(1) ? k[j] + 1 : k[j] - 1;
                end
                for (int i = n; i < IN_KEYS; i++) k[i] = $urandom;
                for (int i = n - 1; i > 0; i--) begin
                    j    = $urandom_range(i);
                    tmp  = k[i];
                    k[i] = k[j];
                    k[j] = tmp;
                end
                push_probe(k);
            end else if (op < 75) begin
                for (int i = 0; i < IN_KEYS; i++) k[i] = $urandom;
                push_probe(k);
            end else if (op < 85) begin
                push_walk_append();
            end else if (op < 90) begin
                // Out-of-order append with unsorted words: the search then runs
                // over a table that is no longer sorted.
                push_beat(mk_beat(KIND_APPEND, $urandom, $urandom, $urandom, $urandom,
                                  $urandom), 1'b0, '0);
            end else if (op < 95) begin
                push_beat(mk_beat(KIND_NOP, $urandom, $urandom, $urandom, $urandom,
                                  $urandom), 1'b0, '0);
            end else if (op < 98) begin
                push_beat(mk_beat(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom), 1'b0, '0);
                reset_key_walk();
                repeat ($urandom_range(20)) push_walk_append();
            end else begin
                // Let the block run dry, then probe just past the end of the walk.
                wait_results_drained();
                k = next_walk_key();
                push_probe(k);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        got = out_data;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending", '0, 32'(got.position));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.found !== want.found)
                    note_mismatch("found", 32'(want.found), 32'(got.found));
                if (got.found_value !== want.found_value)
                    note_mismatch("found_value", want.found_value, got.found_value);
                if (got.position !== want.position)
                    note_mismatch("position", 32'(want.position), 32'(got.position));
            end
        end
        // Any beat on either channel, or a register access, counts as progress.
        if ((out_valid && out_ready) || (in_valid && in_ready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Empty table first: a probe lands at zero, and no-op and clear return all
        // zeros. Then a small sorted table built from the extreme words.
        add_row(NO_CFG, mk_beat(KIND_PROBE, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_NOP, W_ONES, W_ONES, W_ONES, W_ONES, W_ONES),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_CLEAR, W_MAX, W_MIN, W_ONES, W_ZERO, W_ONES),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_APPEND, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_APPEND, W_ONES, W_ZERO, 32'd1, 32'd2, W_MIN),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 1));
        add_row(NO_CFG, mk_beat(KIND_APPEND, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ONES),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 2));
        add_row(NO_CFG, mk_beat(KIND_APPEND, W_MAX, W_MAX, W_MAX, W_MAX, W_ZERO),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 3));
        // Probes: a shuffled hit, both ends of the table, and a near miss at the top.
        add_row(NO_CFG, mk_beat(KIND_PROBE, 32'd2, 32'd1, W_ZERO, W_ONES, W_ZERO),
                1'b0, '0);
        add_row(NO_CFG, mk_beat(KIND_PROBE, W_MAX, W_MAX, W_MAX, W_MAX, W_ONES),
                1'b0, '0);
        add_row(NO_CFG, mk_beat(KIND_PROBE, W_MIN, W_MIN, W_MIN, W_MIN, W_ZERO),
                1'b0, '0);
        add_row(NO_CFG, mk_beat(KIND_PROBE, W_MAX, 32'h7FFF_FFFE, W_MAX, W_MAX, W_ZERO),
                1'b0, '0);
        // An out-of-order append is stored as given, and the search runs over it.
        add_row(NO_CFG, mk_beat(KIND_APPEND, 32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD,
                                32'hFFFF_FFFD, 32'h1234_5678),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 4));
        add_row(NO_CFG, mk_beat(KIND_PROBE, 32'd5, 32'd5, 32'd5, 32'd5, W_ZERO), 1'b0, '0);
        // key_len of zero acts as one, and a key_len above four acts as four.
        add_row(0, mk_beat(KIND_PROBE, W_ZERO, W_MAX, W_MAX, W_MAX, W_ZERO), 1'b0, '0);
        add_row(7, mk_beat(KIND_PROBE, 32'd1, W_ZERO, W_ONES, 32'd2, W_ZERO), 1'b0, '0);
        add_row(2, mk_beat(KIND_PROBE, W_ZERO, W_ONES, 32'd9, 32'd9, W_ZERO), 1'b0, '0);
        add_row(NO_CFG, mk_beat(KIND_NOP, 32'h1234_5678, W_MIN, W_MAX, W_ZERO, W_MIN),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_CLEAR, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_PROBE, W_MAX, W_MAX, W_MAX, W_MAX, W_ZERO),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        // An appended key keeps its words unsorted. Only the probe sorts.
        add_row(NO_CFG, mk_beat(KIND_APPEND, 32'd4, 32'd3, 32'd2, 32'd1, 32'h5555_5555),
                1'b1, mk_res(1'b0, 1'b0, W_ZERO, 0));
        add_row(NO_CFG, mk_beat(KIND_PROBE, 32'd4, 32'd3, 32'd2, 32'd1, W_ZERO), 1'b0, '0);
        add_row(4, mk_beat(KIND_PROBE, 32'd1, 32'd2, 32'd3, 32'd4, W_ZERO), 1'b0, '0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 72;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_en) set_key_len(dir_rows[r].cfg_val);
            push_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) run_random_phase(ph);

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/stt_pkg.sv
sv/stt_key_cmp.sv
sv/sorted_tuple_table_probe.sv
sv/stt_checker.sv
test/tb_top.sv
